// File: rtl/lara_pkg.sv
package lara_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned LagDepth  = 4;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [WordWidth-1:0] SEED_ONE_RESET   = 32'hffde1534;
   localparam logic [WordWidth-1:0] SEED_TWO_RESET   = 32'hffde1534;
   localparam logic [WordWidth-1:0] SEED_THREE_RESET = 32'h001a1010;
   localparam logic [WordWidth-1:0] SEED_FOUR_RESET  = 32'hf61a1890;

   localparam logic [CsrIndexWidth-1:0] CSR_SEED_ONE   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED_TWO   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED_THREE = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED_FOUR  = 2'd3;

   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_RESEED = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef struct packed {
      logic draw;
      logic reseed;
   } lag_ctrl_type;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] dividend;
      logic [WordWidth-1:0] divisor;
   } div_cmd_type;

endpackage

// File: rtl/lara_req_if.sv
interface lara_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] divisor;

   modport source (output valid, output cmd, output divisor, input ready);
   modport sink (input valid, input cmd, input divisor, output ready);
endinterface

// File: rtl/lara_rsp_if.sv
interface lara_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_value;
   logic [31:0] ranged_value;
   logic        divide_error;

   modport source (output valid, output raw_value, output ranged_value,
                   output divide_error, input ready);
   modport sink (input valid, input raw_value, input ranged_value,
                 input divide_error, output ready);
endinterface

// File: rtl/lagged_add_random_ranged_top.sv
// Lagged additive random generator with a ranged output.
// req_chan: cmd (draw or reseed) and a 32-bit divisor; a transfer happens
// when valid and ready are both high. rsp_chan: raw_value, ranged_value
// (raw_value modulo divisor) and divide_error, one transfer per draw.
// csr_*: write the four seed registers by index; writes take effect at once
// and are meant to be done while the block is idle.
// A draw advances the lags at its transfer and runs a radix-2 restoring
// divider, one quotient bit per cycle, then loads the result into the
// output register once that register is free.
// A reseed reloads the lags from the seed registers at its transfer and
// gives no response.
// A zero divisor still advances the lags; ranged_value is 0 and
// divide_error is 1.
// req_chan.ready is low while the divider runs. A waiting response does not
// block the next request; a finished division waits in the divider until
// the output register is free.
// Reset (synchronous) loads the default seeds into seed and lag registers
// and empties the output register.
module lagged_add_random_ranged_top (
   input  logic        clock,
   input  logic        reset,
   lara_req_if.sink    req_chan,
   lara_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   lara_pkg::state_type    state_ff, state_in;
   lara_pkg::lag_ctrl_type lag_ctrl;
   lara_pkg::div_cmd_type  div_cmd;

   logic        req_xfer;
   logic        out_free;
   logic        div_done;
   logic [31:0] div_rem;
   logic [31:0] next_sum;
   logic        load_out;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] raw_ff;
   logic        zero_ff;
   logic [31:0] out_raw_ff;
   logic [31:0] out_ranged_ff;
   logic        out_err_ff;

   assign req_chan.ready = (state_ff == lara_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   assign lag_ctrl.draw   = req_xfer && (req_chan.cmd == lara_pkg::CMD_DRAW);
   assign lag_ctrl.reseed = req_xfer && (req_chan.cmd == lara_pkg::CMD_RESEED);

   assign div_cmd.start    = lag_ctrl.draw;
   assign div_cmd.dividend = next_sum;
   assign div_cmd.divisor  = req_chan.divisor;

   lara_lags u_lags (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (lag_ctrl),
      .next_sum  (next_sum)
   );

   lara_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         lara_pkg::ST_IDLE: begin
            if (lag_ctrl.draw) begin
               state_in = lara_pkg::ST_BUSY;
            end
         end
         lara_pkg::ST_BUSY: begin
            if (div_done && out_free) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = lara_pkg::ST_IDLE;
            end
         end
         default: state_in = lara_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lara_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lag_ctrl.draw) begin
         raw_ff  <= next_sum;
         zero_ff <= (req_chan.divisor == 32'd0);
      end
      if (load_out) begin
         out_raw_ff    <= raw_ff;
         out_ranged_ff <= zero_ff ? 32'd0 : div_rem;
         out_err_ff    <= zero_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.raw_value    = out_raw_ff;
   assign rsp_chan.ranged_value = out_ranged_ff;
   assign rsp_chan.divide_error = out_err_ff;

endmodule

// File: rtl/lara_lags.sv
module lara_lags (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [lara_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [lara_pkg::WordWidth-1:0]         csr_wdata,
   input  lara_pkg::lag_ctrl_type                 ctrl,
   output logic [lara_pkg::WordWidth-1:0]         next_sum
);

   logic [lara_pkg::WordWidth-1:0] seed_ff [lara_pkg::LagDepth];
   logic [lara_pkg::WordWidth-1:0] lag_ff  [lara_pkg::LagDepth];
   logic [lara_pkg::WordWidth:0]   pair_sum;

   // end-around carry, then one more
   assign pair_sum = {1'b0, lag_ff[0]} + {1'b0, lag_ff[3]};
   assign next_sum = pair_sum[lara_pkg::WordWidth-1:0]
                     + {{(lara_pkg::WordWidth-1){1'b0}}, pair_sum[lara_pkg::WordWidth]}
                     + {{(lara_pkg::WordWidth-1){1'b0}}, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[0] <= lara_pkg::SEED_ONE_RESET;
         seed_ff[1] <= lara_pkg::SEED_TWO_RESET;
         seed_ff[2] <= lara_pkg::SEED_THREE_RESET;
         seed_ff[3] <= lara_pkg::SEED_FOUR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lara_pkg::CSR_SEED_ONE:   seed_ff[0] <= csr_wdata;
            lara_pkg::CSR_SEED_TWO:   seed_ff[1] <= csr_wdata;
            lara_pkg::CSR_SEED_THREE: seed_ff[2] <= csr_wdata;
            lara_pkg::CSR_SEED_FOUR:  seed_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff[0] <= lara_pkg::SEED_ONE_RESET;
         lag_ff[1] <= lara_pkg::SEED_TWO_RESET;
         lag_ff[2] <= lara_pkg::SEED_THREE_RESET;
         lag_ff[3] <= lara_pkg::SEED_FOUR_RESET;
      end else if (ctrl.reseed) begin
         lag_ff <= seed_ff;
      end else if (ctrl.draw) begin
         lag_ff[0] <= next_sum;
         lag_ff[1] <= lag_ff[0];
         lag_ff[2] <= lag_ff[1];
         lag_ff[3] <= lag_ff[2];
      end
   end

endmodule

// File: rtl/lara_div.sv
module lara_div (
   input  logic                           clock,
   input  logic                           reset,
   input  lara_pkg::div_cmd_type          cmd,
   output logic                           done,
   output logic [lara_pkg::WordWidth-1:0] remainder
);

   localparam int unsigned W  = lara_pkg::WordWidth;
   localparam int unsigned CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = diff[W] ? trial[W-1:0] : diff[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomPhases = 6;
   localparam int ItemsPerPhase = 225;
   localparam int SettleCycles = 40;
   localparam int LongHold = 300;
   localparam int HoldAfterResults = 400;
   localparam int StallLimit = 2000;
   localparam int DirectedRows = 22;

   typedef struct packed {
      logic [lara_pkg::WordWidth-1:0] raw_value;
      logic [lara_pkg::WordWidth-1:0] ranged_value;
      logic                           divide_error;
   } draw_result_type;

   typedef struct packed {
      logic                           cmd;
      logic [lara_pkg::WordWidth-1:0] divisor;
      logic                           typed;
      logic [lara_pkg::WordWidth-1:0] raw_value;
      logic [lara_pkg::WordWidth-1:0] ranged_value;
      logic                           divide_error;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               csr_we;
   logic [lara_pkg::CsrIndexWidth-1:0] csr_index;
   logic [lara_pkg::WordWidth-1:0]     csr_wdata;

   lara_req_if req_bus ();
   lara_rsp_if rsp_bus ();

   lagged_add_random_ranged_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   logic [lara_pkg::WordWidth-1:0] seed_shadow [lara_pkg::LagDepth];
   logic [lara_pkg::WordWidth-1:0] lag_state [lara_pkg::LagDepth];
   draw_result_type                pending_draws [$];
   int                             mismatch_count = 0;
   int                             results_seen = 0;
   bit                             quiet_phase = 1'b0;
   int                             quiet_cycles = 0;

   // rows with typed set (first draws from the default seeds) hold typed-in results; the rest use predict_draw
   directed_row_type directed_rows [DirectedRows] = '{
      '{lara_pkg::CMD_DRAW,   32'h00000000, 1'b1, 32'hf5f82dc6, 32'h00000000, 1'b1},
      '{lara_pkg::CMD_DRAW,   32'hffffffff, 1'b1, 32'hf6123dd7, 32'hf6123dd7, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00000001, 1'b1, 32'hf5f0530d, 32'h00000000, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h80000000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00000002, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h7fffffff, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_RESEED, 32'h00000000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00000000, 1'b1, 32'hf5f82dc6, 32'h00000000, 1'b1},
      '{lara_pkg::CMD_DRAW,   32'h00000003, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'hfffffffe, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h0000ffff, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00000000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_RESEED, 32'hffffffff, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'hffffffff, 1'b1, 32'hf5f82dc6, 32'hf5f82dc6, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h0000000a, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h55555555, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'haaaaaaaa, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00010000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_RESEED, 32'h00000000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_RESEED, 32'h12345678, 1'b0, 32'h0, 32'h0, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'hf5f82dc6, 1'b1, 32'hf5f82dc6, 32'h00000000, 1'b0},
      '{lara_pkg::CMD_DRAW,   32'h00000007, 1'b0, 32'h0, 32'h0, 1'b0}
   };

   function automatic void reload_lags();
      for (int k = 0; k < lara_pkg::LagDepth; k++) lag_state[k] = seed_shadow[k];
   endfunction

   function automatic draw_result_type predict_draw(
         input logic [lara_pkg::WordWidth-1:0] divisor);
      logic [lara_pkg::WordWidth:0]   wide_sum;
      logic [lara_pkg::WordWidth-1:0] sum;
      draw_result_type                result;
      wide_sum = {1'b0, lag_state[0]} + {1'b0, lag_state[lara_pkg::LagDepth-1]};
      sum = wide_sum[lara_pkg::WordWidth-1:0]
            + lara_pkg::WordWidth'(wide_sum[lara_pkg::WordWidth]) + 32'd1;
      for (int k = lara_pkg::LagDepth - 1; k > 0; k--) lag_state[k] = lag_state[k-1];
      lag_state[0] = sum;
      result.raw_value = sum;
      if (divisor == '0) begin
         result.ranged_value = '0;
         result.divide_error = 1'b1;
      end else begin
         result.ranged_value = sum % divisor;
         result.divide_error = 1'b0;
      end
      return result;
   endfunction

   function automatic logic [lara_pkg::WordWidth-1:0] pick_divisor();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(1, 16);
         2: return 32'h1 << $urandom_range(0, 31);
         3: return 32'hffffffff - $urandom_range(0, 15);
         4: return $urandom_range(1, 65535);
         default: return $urandom();
      endcase
   endfunction

   task automatic load_seed_bank(input logic [lara_pkg::WordWidth-1:0] s1,
                                 input logic [lara_pkg::WordWidth-1:0] s2,
                                 input logic [lara_pkg::WordWidth-1:0] s3,
                                 input logic [lara_pkg::WordWidth-1:0] s4);
      csr_we <= 1'b1;
      csr_index <= lara_pkg::CSR_SEED_ONE;
      csr_wdata <= s1;
      @(posedge clock);
      csr_index <= lara_pkg::CSR_SEED_TWO;
      csr_wdata <= s2;
      @(posedge clock);
      csr_index <= lara_pkg::CSR_SEED_THREE;
      csr_wdata <= s3;
      @(posedge clock);
      csr_index <= lara_pkg::CSR_SEED_FOUR;
      csr_wdata <= s4;
      @(posedge clock);
      csr_we <= 1'b0;
      seed_shadow[lara_pkg::CSR_SEED_ONE] = s1;
      seed_shadow[lara_pkg::CSR_SEED_TWO] = s2;
      seed_shadow[lara_pkg::CSR_SEED_THREE] = s3;
      seed_shadow[lara_pkg::CSR_SEED_FOUR] = s4;
   endtask

   task automatic offer_item(input logic cmd, input logic [lara_pkg::WordWidth-1:0] divisor);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.divisor <= divisor;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // sender and phase control
   initial begin
      directed_row_type               row;
      draw_result_type                predicted;
      logic                           cmd;
      logic [lara_pkg::WordWidth-1:0] divisor;
      req_bus.valid = 1'b0;
      req_bus.cmd = lara_pkg::CMD_DRAW;
      req_bus.divisor = '0;
      csr_we = 1'b0;
      csr_index = lara_pkg::CSR_SEED_ONE;
      csr_wdata = '0;
      seed_shadow[lara_pkg::CSR_SEED_ONE] = lara_pkg::SEED_ONE_RESET;
      seed_shadow[lara_pkg::CSR_SEED_TWO] = lara_pkg::SEED_TWO_RESET;
      seed_shadow[lara_pkg::CSR_SEED_THREE] = lara_pkg::SEED_THREE_RESET;
      seed_shadow[lara_pkg::CSR_SEED_FOUR] = lara_pkg::SEED_FOUR_RESET;
      reload_lags();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer_item(row.cmd, row.divisor);
         if (row.cmd == lara_pkg::CMD_RESEED) begin
            reload_lags();
         end else begin
            predicted = predict_draw(row.divisor);
            if (row.typed)
               pending_draws.push_back({row.raw_value, row.ranged_value, row.divide_error});
            else
               pending_draws.push_back(predicted);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         drain_and_settle();
         case (phase)
            0: load_seed_bank('0, '0, '0, '0);
            1: load_seed_bank('1, '1, '1, '1);
            2: load_seed_bank('0, '1, '0, '1);
            default: load_seed_bank($urandom(), $urandom(), $urandom(), $urandom());
         endcase
         quiet_phase = (phase == 3);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            cmd = (n == 0 || $urandom_range(0, 11) == 0) ? lara_pkg::CMD_RESEED
                                                         : lara_pkg::CMD_DRAW;
            divisor = pick_divisor();
            offer_item(cmd, divisor);
            if (cmd == lara_pkg::CMD_RESEED)
               reload_lags();
            else
               pending_draws.push_back(predict_draw(divisor));
         end
         quiet_phase = 1'b0;
      end

      drain_and_settle();
      if (mismatch_count == 0)
         $display("PASS lagged_add_random_ranged_top");
      else
         $display("FAIL lagged_add_random_ranged_top");
      $finish;
   end

   // receiver and result check
   initial begin
      draw_result_type want;
      int              stall;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (results_seen == HoldAfterResults)
            stall = LongHold;
         else
            stall = quiet_phase ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         results_seen++;
         if (pending_draws.size() == 0) begin
            $error("result transfer with no draw outstanding: raw_value %h", rsp_bus.raw_value);
            mismatch_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_bus.raw_value !== want.raw_value) begin
               $error("raw_value: expected %h, actual %h", want.raw_value, rsp_bus.raw_value);
               mismatch_count++;
            end
            if (rsp_bus.ranged_value !== want.ranged_value) begin
               $error("ranged_value: expected %h, actual %h",
                      want.ranged_value, rsp_bus.ranged_value);
               mismatch_count++;
            end
            if (rsp_bus.divide_error !== want.divide_error) begin
               $error("divide_error: expected %b, actual %b",
                      want.divide_error, rsp_bus.divide_error);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on transfer activity
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("FAIL lagged_add_random_ranged_top");
         $finish;
      end
   end

endmodule

// File: files.f
rtl/lara_pkg.sv
rtl/lara_req_if.sv
rtl/lara_rsp_if.sv
rtl/lara_lags.sv
rtl/lara_div.sv
rtl/lagged_add_random_ranged_top.sv
bench/testbench.sv
